### src/length_prefixed_message_deframer_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed message deframer
// Shared assertion wrappers. They expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define LPMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define LPMD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/lpmd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_pkg
// Types and constants shared by the deframer front end, queue and back end.
// ---------------------------------------------------------------------------
package lpmd_pkg;

	// Holds a header job plus the payload bytes that arrive while it drains.
	localparam int unsigned LPMD_QUEUE_DEPTH = 5;

	localparam logic [31:0] LPMD_HEADER_BYTES = 32'd4;
	localparam logic [31:0] LPMD_MAX_LEN_RESET = 32'hFFFF_FFFF;
	// Index of the fourth (last) header byte.
	localparam logic [1:0] LPMD_LAST_HDR_IDX = 2'd3;

	typedef enum logic [1:0] {
		KIND_MSG   = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_LONG  = 2'd2,
		KIND_DROP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_BYTE   = 2'd0,
		OP_HEADER = 2'd1,
		OP_ERROR  = 2'd2
	} op_t;

	// One queued job for the back end.
	typedef struct packed {
		op_t         op;
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
		logic [31:0] len;
	} q_entry_t;

endpackage

### src/lpmd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_front
// Accepts stream bytes, tracks the framing state and queues at most one job per item.
// ---------------------------------------------------------------------------
`include "length_prefixed_message_deframer_top_defines.svh"

module lpmd_front import lpmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        q_full,
	output logic        q_push,
	output q_entry_t    q_entry
);

	logic [31:0] max_len_q;
	logic [23:0] header_shift_q, header_shift_n;
	logic [1:0]  header_count_q, header_count_n;
	logic [31:0] bytes_remaining_q, bytes_remaining_n;
	logic        skipping_q, skipping_n;
	logic [31:0] current_length_q, current_length_n;

	logic        accept;
	logic [31:0] len_full;
	logic [31:0] len_body;
	logic [31:0] remaining_dec;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;
	assign len_full      = {s_axis_tdata, header_shift_q};
	assign len_body      = len_full - LPMD_HEADER_BYTES;
	assign remaining_dec = bytes_remaining_q - 32'd1;

	always_comb begin
		header_shift_n    = header_shift_q;
		header_count_n    = header_count_q;
		bytes_remaining_n = bytes_remaining_q;
		skipping_n        = skipping_q;
		current_length_n  = current_length_q;
		q_push            = 1'b0;
		q_entry           = '{op: OP_BYTE, kind: KIND_MSG, data: 8'd0, last: 1'b0,
			len: 32'd0};
		if (accept) begin
			if (s_axis_tuser) begin
				// Close: report a partial message, then clear the framing state.
				if (header_count_q != 2'd0) begin
					q_push       = 1'b1;
					q_entry.op   = OP_ERROR;
					q_entry.kind = KIND_DROP;
				end else if (bytes_remaining_q != 32'd0 || skipping_q) begin
					q_push       = 1'b1;
					q_entry.op   = OP_ERROR;
					q_entry.kind = KIND_DROP;
					q_entry.len  = current_length_q;
				end
				header_shift_n    = '0;
				header_count_n    = '0;
				bytes_remaining_n = '0;
				skipping_n        = 1'b0;
				current_length_n  = '0;
			end else if (skipping_q) begin
				if (bytes_remaining_q != 32'd0) begin
					bytes_remaining_n = remaining_dec;
				end
				skipping_n = (bytes_remaining_q > 32'd1);
			end else if (bytes_remaining_q != 32'd0) begin
				q_push            = 1'b1;
				q_entry.data      = s_axis_tdata;
				q_entry.last      = (bytes_remaining_q == 32'd1);
				q_entry.len       = current_length_q;
				bytes_remaining_n = remaining_dec;
			end else if (header_count_q != LPMD_LAST_HDR_IDX) begin
				header_shift_n[{header_count_q, 3'b000} +: 8] = s_axis_tdata;
				header_count_n = header_count_q + 2'd1;
			end else begin
				header_shift_n = '0;
				header_count_n = '0;
				q_push         = 1'b1;
				q_entry.len    = len_full;
				if (len_full < LPMD_HEADER_BYTES) begin
					q_entry.op   = OP_ERROR;
					q_entry.kind = KIND_SHORT;
				end else begin
					current_length_n  = len_full;
					bytes_remaining_n = len_body;
					if (len_full > max_len_q) begin
						q_entry.op   = OP_ERROR;
						q_entry.kind = KIND_LONG;
						skipping_n   = (len_body != 32'd0);
					end else begin
						q_entry.op = OP_HEADER;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q         <= LPMD_MAX_LEN_RESET;
			header_shift_q    <= '0;
			header_count_q    <= '0;
			bytes_remaining_q <= '0;
			skipping_q        <= 1'b0;
			current_length_q  <= '0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			header_shift_q    <= header_shift_n;
			header_count_q    <= header_count_n;
			bytes_remaining_q <= bytes_remaining_n;
			skipping_q        <= skipping_n;
			current_length_q  <= current_length_n;
		end
	end

	`LPMD_ASSERT(a_skip_has_count, skipping_q |-> bytes_remaining_q != 32'd0, "skipping with no bytes left")
	`LPMD_ASSERT(a_hunt_is_clean, (header_count_q != 2'd0) |-> (bytes_remaining_q == 32'd0 && !skipping_q), "header collection overlaps a payload")

endmodule

### src/lpmd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_fifo
// Small register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`include "length_prefixed_message_deframer_top_defines.svh"

module lpmd_fifo import lpmd_pkg::*; #(
	parameter int unsigned DEPTH = LPMD_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_entry,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output q_entry_t rd_entry
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_FULL);
	assign valid    = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`LPMD_ASSERT(a_count_bound, count_q <= CNT_FULL, "queue count beyond depth")
	`LPMD_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")

endmodule

### src/lpmd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpmd_back
// Drains queued jobs into the output register; a header job yields 4 results.
// ---------------------------------------------------------------------------
`include "length_prefixed_message_deframer_top_defines.svh"

module lpmd_back import lpmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  q_entry_t    q_entry,
	output logic        q_pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	logic [1:0]  beat_q;
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [7:0]  out_byte_q;
	logic        out_first_q;
	logic        out_last_q;
	logic [31:0] out_len_q;

	logic        advance;
	logic        job_done;
	kind_t       res_kind;
	logic [7:0]  res_byte;
	logic        res_first;
	logic        res_last;

	assign advance  = q_valid && (!out_valid_q || m_axis_tready);
	assign job_done = (q_entry.op != OP_HEADER) || (beat_q == LPMD_LAST_HDR_IDX);
	assign q_pop    = advance && job_done;

	always_comb begin
		res_kind  = KIND_MSG;
		res_byte  = 8'd0;
		res_first = 1'b0;
		res_last  = 1'b0;
		case (q_entry.op)
			OP_BYTE: begin
				res_byte = q_entry.data;
				res_last = q_entry.last;
			end
			OP_HEADER: begin
				// Header bytes go out little-endian, as they arrived.
				res_byte  = q_entry.len[{beat_q, 3'b000} +: 8];
				res_first = (beat_q == 2'd0);
				res_last  = (beat_q == LPMD_LAST_HDR_IDX) &&
					(q_entry.len == LPMD_HEADER_BYTES);
			end
			OP_ERROR: begin
				res_kind = q_entry.kind;
			end
			default: begin
				res_kind = q_entry.kind;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_kind_q  <= res_kind;
			out_byte_q  <= res_byte;
			out_first_q <= res_first;
			out_last_q  <= res_last;
			out_len_q   <= q_entry.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				beat_q      <= job_done ? 2'd0 : beat_q + 2'd1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_byte_q};
	assign m_axis_tuser  = {out_first_q, out_kind_q};
	assign m_axis_tlast  = out_last_q;

	`LPMD_ASSERT(a_beat_in_header, (beat_q != 2'd0) |-> (q_valid && q_entry.op == OP_HEADER), "header beat without a header job")
	`LPMD_ASSERT(a_first_is_len_lsb, (out_valid_q && out_first_q) |-> (out_kind_q == KIND_MSG && out_byte_q == out_len_q[7:0]), "first byte is not the length low byte")

endmodule

### src/length_prefixed_message_deframer_top.sv
`timescale 1ns / 1ps
// Throughput: one byte transfer per cycle, sustained while the job queue has room; each result
// leaves at one per cycle while the master side is ready. The first result of a byte reaches the
// master side through the job queue and then the output register. A completed header becomes
// four results; the five-entry job queue between the front end and the back end absorbs that
// burst while the next payload bytes come in.
// Reset (arst_n low, asynchronous): framing state, queue and output valid clear and the
// maximum message length returns to all ones.
// ---------------------------------------------------------------------------
// length_prefixed_message_deframer_top
// Splits a byte stream into messages that open with a 4-byte little-endian
// total length, marking first and last bytes and reporting framing errors.
// ---------------------------------------------------------------------------

module length_prefixed_message_deframer_top import lpmd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = LPMD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Maximum message length register, written whenever cfg_we is high.
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// Slave side.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tuser,  // [0] cmd: 0 data byte, 1 connection closed
	// Master side.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] out_byte, [39:8] message_length
	output logic [2:0]  m_axis_tuser,  // [1:0] kind, [2] first_of_message
	output logic        m_axis_tlast   // last_of_message
);

	// The front end decides on each byte transfer at once and queues at most one job per
	// transfer: a payload byte, a complete header, or an error report. The back end turns
	// jobs into results, so a stalled master side only backs up the queue, and the slave
	// side keeps taking bytes until the queue fills.
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;
	q_entry_t q_wr_entry;
	q_entry_t q_rd_entry;

	lpmd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_wr_entry)
	);

	// Job queue; a header job stays at its head until all four header bytes are sent.
	lpmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.rd_entry (q_rd_entry)
	);

	// The back end owns the output register, so a new result loads in the same cycle the
	// previous one transfers.
	lpmd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (q_rd_entry),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-prefixed message deframer testbench
// Drives byte and close transfers into the deframer and tracks the framing
// state alongside it. Every result transfer is checked field by field
// against the oldest predicted result. Runs directed framing cases, the
// length limit at its extremes, three random traffic phases with different
// idle patterns, and a long output stall that backs up the input.
// ---------------------------------------------------------------------------

module testbench;
	import lpmd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	// Quiet cycles before a register write, since header and skipped bytes give no result.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned STALL_CYCLES = 300;
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_CLOSE = 1'b1;

	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] len;
	} frame_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Shadow of the deframer state and its length limit.
	logic [23:0] hdr_bits;
	logic [2:0]  hdr_seen;
	logic [31:0] body_left;
	logic        discarding;
	logic [31:0] msg_len;
	logic [31:0] limit_len;

	frame_result_t expected_results[$];
	int unsigned   errors = 0;
	int unsigned   cycles = 0;
	int unsigned   items_sent = 0;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	bit            stall_request = 1'b0;
	int unsigned   stall_left = 0;

	length_prefixed_message_deframer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver stalls at random, or for a long stretch when a test asks for one.
	always @(posedge clk) begin
		if (stall_request) begin
			stall_left = STALL_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Every result transfer is matched against the oldest outstanding prediction.
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: tdata 0x%0h tuser 0x%0h tlast %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_axis_tuser[1:0]));
				check_field("out_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
				check_field("first_of_message", 32'(want.first), 32'(m_axis_tuser[2]));
				check_field("last_of_message", 32'(want.last), 32'(m_axis_tlast));
				check_field("message_length", want.len, m_axis_tdata[39:8]);
			end
		end
	end

	function automatic void push_result(kind_t kind, logic [7:0] data, logic first,
			logic last, logic [31:0] len);
		frame_result_t r;
		r.kind = kind;
		r.data = data;
		r.first = first;
		r.last = last;
		r.len = len;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void clear_framing();
		hdr_bits = '0;
		hdr_seen = '0;
		body_left = '0;
		discarding = 1'b0;
		msg_len = '0;
	endfunction

	// Advances the framing shadow by one accepted transfer and queues what it yields.
	function automatic void predict_deframed(logic cmd, logic [7:0] b);
		logic [31:0] len;
		if (cmd == CMD_CLOSE) begin
			if (hdr_seen != 0)
				push_result(KIND_DROP, 8'h00, 1'b0, 1'b0, 32'd0);
			else if (body_left != 0 || discarding)
				push_result(KIND_DROP, 8'h00, 1'b0, 1'b0, msg_len);
			clear_framing();
			return;
		end
		if (discarding) begin
			if (body_left != 0)
				body_left--;
			if (body_left == 0)
				discarding = 1'b0;
			return;
		end
		if (body_left != 0) begin
			push_result(KIND_MSG, b, 1'b0, body_left == 1, msg_len);
			body_left--;
			return;
		end
		if (hdr_seen < 3) begin
			hdr_bits[8 * hdr_seen +: 8] = b;
			hdr_seen++;
			return;
		end
		len = {b, hdr_bits};
		hdr_bits = '0;
		hdr_seen = '0;
		if (len < LPMD_HEADER_BYTES) begin
			push_result(KIND_SHORT, 8'h00, 1'b0, 1'b0, len);
			return;
		end
		msg_len = len;
		if (len > limit_len) begin
			push_result(KIND_LONG, 8'h00, 1'b0, 1'b0, len);
			body_left = len - LPMD_HEADER_BYTES;
			discarding = (body_left != 0);
			return;
		end
		for (int i = 0; i < 4; i++)
			push_result(KIND_MSG, len[8 * i +: 8], i == 0,
				i == 3 && len == LPMD_HEADER_BYTES, len);
		body_left = len - LPMD_HEADER_BYTES;
	endfunction

	// Offers one transfer, after a random idle gap, and holds it until it is taken.
	task automatic send_item(input logic cmd, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_deframed(cmd, b);
		items_sent++;
	endtask

	task automatic send_header(input logic [31:0] len);
		for (int i = 0; i < 4; i++)
			send_item(CMD_BYTE, len[8 * i +: 8]);
	endtask

	// Header, then a number of random body bytes, then optionally a close.
	task automatic send_message(input logic [31:0] len, input int unsigned body,
			input bit close_after);
		send_header(len);
		for (int unsigned i = 0; i < body; i++)
			send_item(CMD_BYTE, 8'($urandom_range(255)));
		if (close_after)
			send_item(CMD_CLOSE, 8'($urandom_range(255)));
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [31:0] value);
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_len = value;
	endtask

	task automatic test_directed_framing();
		send_idle_pct = 35;
		recv_idle_pct = 75;
		// A close with nothing in progress gives no result.
		send_item(CMD_CLOSE, 8'hFF);
		// A header-only message: the fourth header byte is also the last byte.
		send_message(32'd4, 0, 1'b0);
		send_header(32'd6);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		// Lengths below the header size; hunting restarts on the next byte.
		send_header(32'd0);
		send_header(32'd3);
		// The largest length is accepted under the reset limit, then cut short.
		send_message(32'hFFFF_FFFF, 2, 1'b1);
		// A close during a partial header.
		send_item(CMD_BYTE, 8'hA5);
		send_item(CMD_BYTE, 8'h5A);
		send_item(CMD_CLOSE, 8'h00);
	endtask

	task automatic test_length_limit();
		write_max_length(LPMD_HEADER_BYTES);
		send_message(32'd4, 0, 1'b0);
		// One byte over: reported, its single body byte is skipped.
		send_message(32'd5, 1, 1'b0);
		send_message(32'd4, 0, 1'b0);
		// A close inside a skip reports the dropped message's length.
		send_message(32'd9, 2, 1'b1);
		// With the limit below 4, short lengths are still reported as short.
		write_max_length(32'd3);
		send_header(32'd2);
		send_header(32'd4);
		send_message(32'd3, 0, 1'b0);
		write_max_length(LPMD_MAX_LEN_RESET);
	endtask

	// Mostly well-formed messages with random content, the rest errors and noise.
	task automatic test_random_traffic(input int unsigned sender_pct,
			input int unsigned receiver_pct, input logic [31:0] max_len, input int unsigned budget);
		int unsigned first_item;
		int unsigned pick;
		int unsigned hi;
		int unsigned body;
		logic [31:0] len;
		write_max_length(max_len);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		first_item = items_sent;
		while (items_sent - first_item < budget) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				send_header(32'($urandom_range(3)));
			end else if (pick < 15) begin
				// Partial header, then the connection closes.
				for (int i = $urandom_range(3, 1); i > 0; i--)
					send_item(CMD_BYTE, 8'($urandom_range(255)));
				send_item(CMD_CLOSE, 8'($urandom_range(255)));
			end else if (pick < 20) begin
				send_item(CMD_CLOSE, 8'($urandom_range(255)));
			end else if (pick < 32) begin
				if (limit_len == LPMD_MAX_LEN_RESET) begin
					// Nothing is over the limit; a huge length is cut short instead.
					len = $urandom() | 32'h0000_0100;
					send_message(len, $urandom_range(3), 1'b1);
				end else begin
					len = limit_len + $urandom_range(8, 1);
					body = len - LPMD_HEADER_BYTES;
					if ($urandom_range(3) == 0)
						send_message(len, $urandom_range(body - 1), 1'b1);
					else
						send_message(len, body, 1'b0);
				end
			end else begin
				hi = (limit_len < 16) ? limit_len : 16;
				len = $urandom_range(hi, 4);
				body = len - LPMD_HEADER_BYTES;
				if (body != 0 && $urandom_range(9) == 0)
					send_message(len, $urandom_range(body - 1), 1'b1);
				else
					send_message(len, body, 1'b0);
			end
		end
	endtask

	// The receiver holds off long enough for the job queue to fill and block the input.
	task automatic test_output_stall();
		write_max_length(LPMD_MAX_LEN_RESET);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		send_message(32'd16, 12, 1'b0);
		send_message(32'd4, 0, 1'b0);
	endtask

	initial begin
		limit_len = LPMD_MAX_LEN_RESET;
		clear_framing();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_framing();
		test_length_limit();
		test_random_traffic(35, 75, 32'($urandom_range(20, 8)), 12);
		test_random_traffic(75, 35, LPMD_MAX_LEN_RESET, 12);
		test_random_traffic(0, 0, 32'd12, 12);
		test_output_stall();

		wait_results_drained();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/lpmd_pkg.sv
src/lpmd_front.sv
src/lpmd_fifo.sv
src/lpmd_back.sv
src/length_prefixed_message_deframer_top.sv
bench/testbench.sv
